### design/dnts_pkg.sv
package dnts_pkg;

    localparam int ENTRIES     = 64;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NAME_BYTES  = 11;
    localparam int EXT_OFFSET  = 8;
    localparam int BASE_CHARS  = 8;
    localparam int EXT_CHARS   = 3;
    localparam int MARKER_POS  = 0;

    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] DOT_CHAR       = 8'h2E;
    localparam logic [7:0] MARKER_DEFAULT = 8'd229;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_FOUND = 2'd1,
        ST_MISS  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_FIND,
        S_SEARCH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    scan_start;
        logic    rd_en;
        logic    clr_wr;
        logic    load_wr;
        logic    q_upd;
        logic    q_clear;
        logic    scan_find;
        logic    res_load;
        t_status res_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic last_cmp;
        logic addr_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

endpackage

### design/dnts_in_if.sv
interface dnts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] entry_index;
    logic [3:0] byte_position;
    logic [7:0] byte_value;
    logic       last_char;

    modport source (
        output valid, command, entry_index, byte_position, byte_value, last_char,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, byte_position, byte_value, last_char,
        output ready
    );
endinterface

### design/dnts_out_if.sv
interface dnts_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] found_index;

    modport source (
        output valid, status, found_index,
        input  ready
    );
    modport sink (
        input  valid, status, found_index,
        output ready
    );
endinterface

### design/directory_name_table_search_core.sv
// Directory name table with 8.3 name search.
//
// Items arrive on i_cmd (valid/ready) and each accepted item yields exactly one
// result item on o_res (valid/ready) carrying status and found_index. The
// deleted marker register is written through i_cfg_we/i_cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce this.
// Load name byte and non-final query characters are answered directly: the
// result appears in the output register on the cycle after acceptance.
// Clear all walks every table entry, one per cycle, and loads its result once
// the last entry is written. Find free and the name search walk the table
// through registered memory reads and stop at the first match or after the
// last entry. The single read port of the per-byte name memories means that
// one entry is compared per cycle.
// One item is in flight at a time; a new item is taken when the controller is
// idle and the output register is empty or being emptied in the same cycle.
// A stalled receiver simply holds the result in the output register; the
// block then takes no further item until the result is drained.
// Reset returns the marker to 229, clears the partial query name and empties
// the output register. The name table itself is not cleared by reset.
module directory_name_table_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    dnts_in_if.sink     i_cmd,
    dnts_out_if.source  o_res
);

    dnts_pkg::t_dp_cmd  dp_cmd;
    dnts_pkg::t_dp_stat dp_stat;

    // The controller sequences clear, scan and result loading.
    dnts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_cmd.valid),
        .i_command   (i_cmd.command),
        .i_last_char (i_cmd.last_char),
        .i_stat      (dp_stat),
        .o_ready     (i_cmd.ready),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the name memories, the query name and the result.
    dnts_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_entry_index   (i_cmd.entry_index),
        .i_byte_position (i_cmd.byte_position),
        .i_byte_value    (i_cmd.byte_value),
        .i_cmd           (dp_cmd),
        .i_out_ready     (o_res.ready),
        .o_stat          (dp_stat),
        .o_out_valid     (o_res.valid),
        .o_status        (o_res.status),
        .o_found_index   (o_res.found_index)
    );

endmodule

### design/dnts_ctrl.sv
module dnts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_command,
    input  logic               i_last_char,
    input  dnts_pkg::t_dp_stat i_stat,
    output logic               o_ready,
    output dnts_pkg::t_dp_cmd  o_cmd
);

    dnts_pkg::t_state r_state;
    dnts_pkg::t_state n_state;
    dnts_pkg::t_cmd   cmd;
    logic             accept;

    assign cmd    = dnts_pkg::t_cmd'(i_command);
    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dnts_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        dnts_pkg::CMD_CLEAR: n_state = dnts_pkg::S_CLEAR;
                        dnts_pkg::CMD_FIND:  n_state = dnts_pkg::S_FIND;
                        dnts_pkg::CMD_QUERY: begin
                            if (i_last_char) begin
                                n_state = dnts_pkg::S_SEARCH;
                            end
                        end
                        default: n_state = dnts_pkg::S_IDLE;
                    endcase
                end
            end
            dnts_pkg::S_CLEAR: begin
                if (i_stat.addr_last) begin
                    n_state = dnts_pkg::S_IDLE;
                end
            end
            dnts_pkg::S_FIND, dnts_pkg::S_SEARCH: begin
                if (i_stat.hit || i_stat.last_cmp) begin
                    n_state = dnts_pkg::S_IDLE;
                end
            end
            default: n_state = dnts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.res_status = dnts_pkg::ST_NONE;
        unique case (r_state)
            dnts_pkg::S_IDLE: begin
                o_ready = i_stat.out_free;
                if (accept) begin
                    unique case (cmd)
                        dnts_pkg::CMD_CLEAR: o_cmd.scan_start = 1'b1;
                        dnts_pkg::CMD_LOAD: begin
                            o_cmd.load_wr  = 1'b1;
                            o_cmd.res_load = 1'b1;
                        end
                        dnts_pkg::CMD_FIND: o_cmd.scan_start = 1'b1;
                        dnts_pkg::CMD_QUERY: begin
                            o_cmd.q_upd = 1'b1;
                            if (i_last_char) begin
                                o_cmd.scan_start = 1'b1;
                            end else begin
                                o_cmd.res_load = 1'b1;
                            end
                        end
                        default: o_cmd.q_upd = 1'b0;
                    endcase
                end
            end
            dnts_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.addr_last) begin
                    o_cmd.res_load = 1'b1;
                end
            end
            dnts_pkg::S_FIND, dnts_pkg::S_SEARCH: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.scan_find = (r_state == dnts_pkg::S_FIND);
                if (i_stat.hit) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = dnts_pkg::ST_FOUND;
                end else if (i_stat.last_cmp) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = dnts_pkg::ST_MISS;
                end
                if (r_state == dnts_pkg::S_SEARCH) begin
                    o_cmd.q_clear = i_stat.hit || i_stat.last_cmp;
                end
            end
            default: o_ready = 1'b0;
        endcase
    end

endmodule

### design/dnts_datapath.sv
module dnts_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic [5:0]         i_entry_index,
    input  logic [3:0]         i_byte_position,
    input  logic [7:0]         i_byte_value,
    input  dnts_pkg::t_dp_cmd  i_cmd,
    input  logic               i_out_ready,
    output dnts_pkg::t_dp_stat o_stat,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [5:0]         o_found_index
);

    logic [7:0]     r_marker;
    dnts_pkg::t_idx r_addr;
    dnts_pkg::t_idx r_rd_idx;
    logic           r_rd_pend;
    logic [7:0]     r_rd [dnts_pkg::NAME_BYTES];
    logic [7:0]     r_qn [dnts_pkg::NAME_BYTES];
    logic [3:0]     r_base_cnt;
    logic [1:0]     r_ext_cnt;
    logic           r_in_ext;
    logic           r_out_valid;
    logic [1:0]     r_status;
    logic [5:0]     r_found;

    logic           addr_last;
    logic           load_ok;
    logic           match_name;
    logic           match_free;
    logic [7:0]     up_char;
    dnts_pkg::t_idx wr_addr;
    logic [7:0]     wr_data;

    assign addr_last = (r_addr == dnts_pkg::t_idx'(dnts_pkg::ENTRIES - 1));
    assign load_ok   = (32'(i_entry_index) < 32'(dnts_pkg::ENTRIES))
                    && (i_byte_position < 4'(dnts_pkg::NAME_BYTES));
    assign wr_addr   = i_cmd.load_wr ? dnts_pkg::t_idx'(i_entry_index) : r_addr;
    assign wr_data   = i_cmd.load_wr ? i_byte_value : r_marker;
    assign up_char   = dnts_pkg::to_upper(i_byte_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= dnts_pkg::MARKER_DEFAULT;
        end else if (i_cfg_we) begin
            r_marker <= i_cfg_wdata;
        end
    end

    // One memory per name byte position, all read at the same scan address.
    for (genvar b = 0; b < dnts_pkg::NAME_BYTES; b++) begin : g_lane
        logic [7:0] r_mem [dnts_pkg::ENTRIES];
        logic       we;

        assign we = (i_cmd.load_wr && load_ok && (i_byte_position == 4'(b)))
                 || (i_cmd.clr_wr && (b == dnts_pkg::MARKER_POS));

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[wr_addr] <= wr_data;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rd[b] <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_en;
            if (i_cmd.scan_start) begin
                r_addr <= '0;
            end else if (i_cmd.rd_en || i_cmd.clr_wr) begin
                r_addr <= addr_last ? '0 : r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
    end

    always_comb begin
        match_name = 1'b1;
        for (int p = 0; p < dnts_pkg::NAME_BYTES; p++) begin
            if (r_rd[p] != r_qn[p]) begin
                match_name = 1'b0;
            end
        end
    end

    assign match_free = (r_rd[dnts_pkg::MARKER_POS] == r_marker);

    // Query name assembly: the first dot switches to the extension.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.q_clear) begin
            for (int p = 0; p < dnts_pkg::NAME_BYTES; p++) begin
                r_qn[p] <= dnts_pkg::SPACE_CHAR;
            end
            r_base_cnt <= '0;
            r_ext_cnt  <= '0;
            r_in_ext   <= 1'b0;
        end else if (i_cmd.q_upd) begin
            if (!r_in_ext && i_byte_value == dnts_pkg::DOT_CHAR) begin
                r_in_ext <= 1'b1;
            end else if (!r_in_ext) begin
                if (r_base_cnt < 4'(dnts_pkg::BASE_CHARS)) begin
                    for (int p = 0; p < dnts_pkg::BASE_CHARS; p++) begin
                        if (r_base_cnt == 4'(p)) begin
                            r_qn[p] <= up_char;
                        end
                    end
                    r_base_cnt <= r_base_cnt + 1'b1;
                end
            end else begin
                if (3'(r_ext_cnt) < 3'(dnts_pkg::EXT_CHARS)) begin
                    for (int p = 0; p < dnts_pkg::EXT_CHARS; p++) begin
                        if (r_ext_cnt == 2'(p)) begin
                            r_qn[dnts_pkg::EXT_OFFSET + p] <= up_char;
                        end
                    end
                    r_ext_cnt <= r_ext_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            r_found  <= (i_cmd.res_status == dnts_pkg::ST_FOUND) ? 6'(r_rd_idx) : 6'd0;
        end
    end

    assign o_stat.hit       = r_rd_pend && (i_cmd.scan_find ? match_free : match_name);
    assign o_stat.last_cmp  = r_rd_pend
                           && (r_rd_idx == dnts_pkg::t_idx'(dnts_pkg::ENTRIES - 1));
    assign o_stat.addr_last = addr_last;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found;

endmodule

### dv/directory_name_table_search_core_tb.sv
module directory_name_table_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dnts_pkg::*;

    // Character constants used to build 8.3 names and query strings.
    localparam logic [7:0] UPPER_A     = 8'h41;
    localparam logic [7:0] UPPER_Z     = 8'h5A;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] DIGIT_0     = 8'h30;
    localparam logic [7:0] TILDE_CHAR  = 8'h7E;

    // The receiver's long hold-off, in cycles. It is far longer than one table
    // walk, so the block parks a result and then refuses further items.
    localparam int LONG_HOLD  = 300;
    // Random items per configuration phase, after the table fill and the
    // directed checks.
    localparam int PHASE_ITEMS = 140;
    localparam int PHASES      = 5;
    // Hard stop for a hung block, several times the slowest legal run.
    localparam int TIMEOUT_NS  = 12_000_000;

    // One command item and one result item as the block sees them.
    typedef struct packed {
        t_cmd       cmd;
        logic [5:0] entry;
        logic [3:0] pos;
        logic [7:0] value;
        logic       last;
    } dir_item_t;

    typedef struct packed {
        t_status status;
        t_idx    found_index;
    } dir_answer_t;

    // Shadow of the directory table and the query assembler. Each accepted
    // item is folded into the shadow state and its answer is queued; each
    // result leaving the block is checked against the oldest queued answer.
    class dir_scoreboard;
        logic [7:0]  name_table [ENTRIES][NAME_BYTES];
        logic [7:0]  query_name [NAME_BYTES];
        int          base_count;
        int          ext_count;
        bit          in_ext;
        logic [7:0]  marker;
        dir_answer_t pending_answers [$];
        int          mismatches;

        function new();
            marker     = MARKER_DEFAULT;
            mismatches = 0;
            foreach (name_table[i, j]) name_table[i][j] = 8'h00;
            reset_query();
        endfunction

        function void reset_query();
            foreach (query_name[i]) query_name[i] = SPACE_CHAR;
            base_count = 0;
            ext_count  = 0;
            in_ext     = 1'b0;
        endfunction

        function void set_marker(logic [7:0] v);
            marker = v;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        function logic [7:0] upcase(logic [7:0] v);
            return (v >= LOWER_A && v <= LOWER_Z) ? v - CASE_OFFSET : v;
        endfunction

        // Computes the answer of one accepted item and queues it.
        function void take_command(dir_item_t c);
            dir_answer_t a;
            bit          hit;
            bit          same;
            a.status      = ST_NONE;
            a.found_index = '0;
            hit           = 1'b0;
            case (c.cmd)
                CMD_CLEAR: begin
                    for (int i = 0; i < ENTRIES; i++) name_table[i][MARKER_POS] = marker;
                end
                CMD_LOAD: begin
                    if (int'(c.entry) < ENTRIES && int'(c.pos) < NAME_BYTES) begin
                        name_table[c.entry][c.pos] = c.value;
                    end
                end
                CMD_FIND: begin
                    for (int i = 0; i < ENTRIES && !hit; i++) begin
                        if (name_table[i][MARKER_POS] == marker) begin
                            hit           = 1'b1;
                            a.found_index = t_idx'(i);
                        end
                    end
                    a.status = hit ? ST_FOUND : ST_MISS;
                end
                CMD_QUERY: begin
                    // Only the first dot switches to the extension; later dots
                    // are kept as ordinary extension characters.
                    if (!in_ext && c.value == DOT_CHAR) begin
                        in_ext = 1'b1;
                    end else if (!in_ext) begin
                        if (base_count < BASE_CHARS) begin
                            query_name[base_count] = upcase(c.value);
                            base_count++;
                        end
                    end else if (ext_count < EXT_CHARS) begin
                        query_name[EXT_OFFSET + ext_count] = upcase(c.value);
                        ext_count++;
                    end
                    if (c.last) begin
                        for (int i = 0; i < ENTRIES && !hit; i++) begin
                            same = 1'b1;
                            for (int j = 0; j < NAME_BYTES; j++) begin
                                if (name_table[i][j] != query_name[j]) same = 1'b0;
                            end
                            if (same) begin
                                hit           = 1'b1;
                                a.found_index = t_idx'(i);
                            end
                        end
                        a.status = hit ? ST_FOUND : ST_MISS;
                        reset_query();
                    end
                end
                default: ;
            endcase
            pending_answers.push_back(a);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 50) $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_answer(logic [1:0] st, logic [5:0] idx);
            dir_answer_t a;
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: status %0d index %0d",
                                          st, idx));
                return;
            end
            a = pending_answers.pop_front();
            if (st !== a.status) begin
                report_mismatch($sformatf("status %0d, predicted %0d", st, a.status));
            end
            if (idx !== a.found_index) begin
                report_mismatch($sformatf("found_index %0d, predicted %0d", idx, a.found_index));
            end
        endtask
    endclass

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    dnts_in_if  cmd_if ();
    dnts_out_if res_if ();

    directory_name_table_search_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dir_scoreboard sb;

    // idle_on and long_hold_req are shared between the stimulus and the receiver
    // process. With idle_on low both sides run flat out; long_hold_req asks the
    // receiver for one long hold-off, which it times itself and then clears.
    bit         idle_on       = 1'b1;
    bit         long_hold_req = 1'b0;
    int         items_sent    = 0;
    logic [7:0] name_buf [NAME_BYTES];
    logic [7:0] name_chars [$];

    // Sender gaps: mostly back to back, sometimes short, rarely long.
    function automatic int sender_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int stall_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // A character for a stored name. Mostly upper case letters and digits,
    // with interior spaces, byte zero and an odd random byte mixed in. Only
    // that byte can give the base part a dot, so names can mostly be typed back.
    function automatic logic [7:0] name_char(bit ext_part);
        int r;
        r = $urandom_range(0, 99);
        if (r < 68) return UPPER_A + 8'($urandom_range(0, 25));
        if (r < 83) return DIGIT_0 + 8'($urandom_range(0, 9));
        if (r < 88) return "_";
        if (r < 91) return SPACE_CHAR;
        if (r < 94) return ext_part ? DOT_CHAR : TILDE_CHAR;
        if (r < 97) return 8'h00;
        return 8'($urandom);
    endfunction

    // A character for a free-form query: letters of either case, dots,
    // digits and arbitrary bytes.
    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return UPPER_A + 8'($urandom_range(0, 25));
        if (r < 50) return LOWER_A + 8'($urandom_range(0, 25));
        if (r < 65) return DOT_CHAR;
        if (r < 80) return DIGIT_0 + 8'($urandom_range(0, 9));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] vary_case(logic [7:0] v);
        if (v >= UPPER_A && v <= UPPER_Z && $urandom_range(0, 1) == 1) return v + CASE_OFFSET;
        return v;
    endfunction

    // Fills name_buf with a space padded 8.3 name.
    function automatic void make_name();
        int blen;
        int elen;
        foreach (name_buf[i]) name_buf[i] = SPACE_CHAR;
        if ($urandom_range(0, 99) < 3) begin
            blen = 0;
        end else begin
            blen = ($urandom_range(0, 3) == 0) ? BASE_CHARS : $urandom_range(1, BASE_CHARS);
        end
        elen = $urandom_range(0, EXT_CHARS);
        for (int i = 0; i < blen; i++) name_buf[i] = name_char(1'b0);
        for (int i = 0; i < elen; i++) name_buf[EXT_OFFSET + i] = name_char(1'b1);
    endfunction

    function automatic void set_name(string s);
        for (int i = 0; i < NAME_BYTES; i++) name_buf[i] = s[i];
    endfunction

    // Turns a stored entry back into a file name as a user would type it:
    // trailing spaces dropped, random case, and sometimes surplus characters
    // past the base or extension limit, which the block must drop.
    function automatic void build_query_for(int e);
        int blen;
        int elen;
        blen = 0;
        elen = 0;
        for (int i = 0; i < EXT_OFFSET; i++) begin
            if (sb.name_table[e][i] != SPACE_CHAR) blen = i + 1;
        end
        for (int i = 0; i < NAME_BYTES - EXT_OFFSET; i++) begin
            if (sb.name_table[e][EXT_OFFSET + i] != SPACE_CHAR) elen = i + 1;
        end
        name_chars.delete();
        for (int i = 0; i < blen; i++) name_chars.push_back(vary_case(sb.name_table[e][i]));
        if (blen == BASE_CHARS && $urandom_range(0, 99) < 35) begin
            repeat ($urandom_range(1, 4)) name_chars.push_back(UPPER_A + 8'($urandom_range(0, 25)));
        end
        // A name without extension sometimes ends in a bare dot.
        if (elen > 0 || blen == 0 || $urandom_range(0, 99) < 30) name_chars.push_back(DOT_CHAR);
        for (int i = 0; i < elen; i++) begin
            name_chars.push_back(vary_case(sb.name_table[e][EXT_OFFSET + i]));
        end
        if (elen == EXT_CHARS && $urandom_range(0, 99) < 35) begin
            repeat ($urandom_range(1, 4)) name_chars.push_back(noise_char());
        end
    endfunction

    // Offers one item, waits for the handshake and notes it for prediction.
    // Fields change only at falling edges; valid is lowered only for a gap.
    task automatic send_item(t_cmd cmd, logic [5:0] entry, logic [3:0] pos,
                             logic [7:0] value, logic last);
        dir_item_t c;
        int        gap;
        c.cmd   = cmd;
        c.entry = entry;
        c.pos   = pos;
        c.value = value;
        c.last  = last;
        gap     = sender_gap();
        if (gap > 0) begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= cmd;
        cmd_if.entry_index   <= entry;
        cmd_if.byte_position <= pos;
        cmd_if.byte_value    <= value;
        cmd_if.last_char     <= last;
        do @(posedge clk); while (!cmd_if.ready);
        sb.take_command(c);
        items_sent++;
    endtask

    task automatic send_random_load();
        send_item(CMD_LOAD, 6'($urandom), 4'($urandom_range(0, 15)), 8'($urandom),
                  1'($urandom));
    endtask

    // A clear, a find or a stray load slipped into the middle of a query.
    task automatic send_other();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send_random_load();
        end else if (r < 88) begin
            send_item(CMD_FIND, 6'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
        end else begin
            send_item(CMD_CLEAR, 6'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // Streams name_chars as query characters; the final one starts the search.
    task automatic send_query(int interrupt_pct);
        int n;
        n = name_chars.size();
        for (int i = 0; i < n; i++) begin
            send_item(CMD_QUERY, 6'($urandom), 4'($urandom), name_chars[i], i == n - 1);
            if (i < n - 1 && $urandom_range(0, 99) < interrupt_pct) send_other();
        end
    endtask

    task automatic query_text(string s);
        name_chars.delete();
        for (int i = 0; i < s.len(); i++) name_chars.push_back(s[i]);
        send_query(0);
    endtask

    task automatic load_name(int e);
        for (int p = 0; p < NAME_BYTES; p++) begin
            send_item(CMD_LOAD, 6'(e), 4'(p), name_buf[p], 1'($urandom));
        end
    endtask

    // The sender withdraws its last item before waiting, so that the block
    // does not take it a second time.
    task automatic drain();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // The marker register is only written with nothing in flight.
    task automatic write_marker(logic [7:0] v);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_marker(v);
    endtask

    // One random action. Most of the traffic is well-formed queries for names
    // that are in the table, so that hits, first-of-duplicates and the
    // truncation rules all get exercised; the rest is table updates, free slot
    // searches, clears and garbage queries.
    task automatic random_action();
        int r;
        int e;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            build_query_for($urandom_range(0, ENTRIES - 1));
            send_query(8);
        end else if (r < 55) begin
            name_chars.delete();
            repeat ($urandom_range(1, 14)) name_chars.push_back(noise_char());
            send_query(5);
        end else if (r < 70) begin
            // Reload one entry, often with a copy of another one so that
            // several entries hold the same name.
            if ($urandom_range(0, 99) < 25) begin
                e = $urandom_range(0, ENTRIES - 1);
                for (int i = 0; i < NAME_BYTES; i++) name_buf[i] = sb.name_table[e][i];
            end else begin
                make_name();
            end
            load_name($urandom_range(0, ENTRIES - 1));
        end else if (r < 80) begin
            send_random_load();
        end else if (r < 90) begin
            send_item(CMD_FIND, 6'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
        end else if (r < 94) begin
            send_item(CMD_CLEAR, 6'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
        end else if (r < 96) begin
            // The sender pauses until every outstanding result is back.
            drain();
        end else begin
            build_query_for($urandom_range(0, ENTRIES - 1));
            send_query(60);
        end
    endtask

    // Receiver: random stalls, flat out when idling is off, and one long
    // hold-off on request while the sender keeps offering items.
    initial begin
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
                res_if.ready <= 1'b1;
            end else if (!idle_on) begin
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 70) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b0;
                stall_left = stall_len() - 1;
            end
        end
    end

    // Results are taken at the rising edge where valid and ready meet.
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            sb.check_answer(res_if.status, res_if.found_index);
        end
    end

    initial begin
        logic [7:0] markers [PHASES];
        int         phase_end;
        sb                   = new();
        cfg_we               = 1'b0;
        cfg_wdata            = 8'h00;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = CMD_CLEAR;
        cmd_if.entry_index   = '0;
        cmd_if.byte_position = '0;
        cmd_if.byte_value    = '0;
        cmd_if.last_char     = 1'b0;
        markers[0] = 8'h00;
        markers[1] = 8'hFF;
        markers[2] = 8'($urandom_range(1, 254));
        markers[3] = UPPER_A;
        markers[4] = MARKER_DEFAULT;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // The name table comes out of reset undefined and every search reads
        // whole entries, so all 64 entries are written before anything reads.
        // A few entries get fixed names for the directed queries below.
        for (int e = 0; e < ENTRIES; e++) begin
            case (e)
                58: begin
                    set_name("           ");
                    name_buf[0] = 8'h00;
                end
                61:      set_name("           ");
                62:      set_name("A       B.C");
                63:      set_name("K       S  ");
                default: make_name();
            endcase
            load_name(e);
        end

        // Directed checks, with the marker still at its reset value.
        // Lower case input must match the upper case entry.
        query_text("k.s");
        // A second dot is an ordinary extension character.
        query_text("a.b.c");
        // A lone dot gives an all-space name.
        query_text(".");
        // Byte zero is an ordinary character.
        name_chars.delete();
        name_chars.push_back(8'h00);
        send_query(0);
        // A partial query survives a find and an out-of-range load.
        send_item(CMD_QUERY, 6'h00, 4'h0, "k", 1'b0);
        send_item(CMD_FIND, 6'h00, 4'h0, 8'h00, 1'b0);
        send_item(CMD_LOAD, 6'h00, 4'hF, 8'hFF, 1'b1);
        query_text(".s");
        // Clear then find free: the lowest entry is free, then the next one.
        send_item(CMD_CLEAR, 6'h3F, 4'hF, 8'hFF, 1'b1);
        send_item(CMD_FIND, 6'h3F, 4'hF, 8'hFF, 1'b1);
        send_item(CMD_LOAD, 6'h00, 4'h0, "R", 1'b0);
        send_item(CMD_FIND, 6'h00, 4'h0, 8'h00, 1'b0);
        send_item(CMD_LOAD, 6'h3F, 4'hA, 8'hFF, 1'b0);
        // Byte position 11 is past the name and must be ignored.
        send_item(CMD_LOAD, 6'h3F, 4'hB, 8'h00, 1'b1);
        send_item(CMD_FIND, 6'h00, 4'h0, 8'h00, 1'b0);

        // Random phases, each with its own marker value. Phase 2 runs with no
        // idling on either side; phases 1 and 3 start with a long receiver
        // hold-off so the block backs up and stalls its input.
        for (int ph = 0; ph < PHASES; ph++) begin
            write_marker(markers[ph]);
            idle_on = (ph != 2);
            if (ph == 1 || ph == 3) long_hold_req = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) random_action();
        end

        @(negedge clk);
        cmd_if.valid <= 1'b0;
        drain();
        // Allow for one more table walk in case a stray result is coming.
        repeat (ENTRIES + 10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("ERROR: timeout with %0d results outstanding", sb.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule
